/* hw/rtl/timed_serial_frame_receiver_core_macros.svh */
// Assertion macros shared by the frame receiver RTL.
`ifndef TIMED_SERIAL_FRAME_RECEIVER_CORE_MACROS_SVH
`define TIMED_SERIAL_FRAME_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tfr_pkg.sv */
// Shared types and constants of the timed serial frame receiver.
package tfr_pkg;

    // Frame geometry
    localparam int unsigned FRAME_BYTES = 7;
    localparam int unsigned IDX_W       = 3;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    // Fixed frame positions of the decoded fields
    localparam logic [IDX_W-1:0] IDX_TYPE  = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_WHOLE = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_TENTH = IDX_W'(5);

    // Configuration port geometry
    localparam int unsigned APB_AW = 5;
    localparam int unsigned APB_DW = 32;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_IDLE_HIGH    = 3'd0;
    localparam logic [2:0] REG_ABSENT_LOW   = 3'd1;
    localparam logic [2:0] REG_FIRST_SAMPLE = 3'd2;
    localparam logic [2:0] REG_BIT_TICKS    = 3'd3;
    localparam logic [2:0] REG_HIGH_POWER   = 3'd4;

    // Register reset values
    localparam logic [9:0]  RST_IDLE_HIGH    = 10'd160;
    localparam logic [11:0] RST_ABSENT_LOW   = 12'd1000;
    localparam logic [7:0]  RST_FIRST_SAMPLE = 8'd15;
    localparam logic [7:0]  RST_BIT_TICKS    = 8'd10;
    localparam logic [7:0]  RST_HIGH_POWER   = 8'd36;

    // Event kinds
    localparam logic EV_BYTE   = 1'b0;
    localparam logic EV_ABSENT = 1'b1;

    // Tenths correction
    localparam logic [7:0] TENTH_LIMIT = 8'd4;
    localparam logic [7:0] TENTH_STEP  = 8'd5;

    typedef struct packed {
        logic [9:0]  idle_high_ticks;
        logic [11:0] absent_low_ticks;
        logic [7:0]  first_sample_ticks;
        logic [7:0]  bit_ticks;
        logic [7:0]  high_power_code;
    } t_cfg;

    typedef struct packed {
        logic             event_kind;
        logic [IDX_W-1:0] byte_index;
        logic [7:0]       byte_value;
        logic [7:0]       temp_whole;
        logic [7:0]       temp_tenth;
        logic             high_power;
        logic             last;
    } t_result;

    // A tick count of zero behaves as one
    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

/* hw/rtl/timed_serial_frame_receiver_core.sv */
// Top level of the timed serial frame receiver.
//
//  channel  direction  handshake                    payload
//  in       in         i_in_valid / o_in_stall      i_line_level
//  out      out        o_out_valid / i_out_stall    o_event_kind .. o_last
//  cfg      in         psel / penable / pwrite      paddr, pwdata, prdata
//
// One tick is taken every cycle unless o_in_stall is high; its result, if
// any, is registered into the output queue. The counter and shift updates
// of one tick fit between the state registers and the output register.
// Reset is synchronous and active low; it restores register defaults and
// the qualification phase. The frame store is not cleared.
// The output register plus a skid stage absorb a stalled output; o_in_stall
// rises only once both hold a beat.
module timed_serial_frame_receiver_core
    import tfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_line_level,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_event_kind,
    output logic [IDX_W-1:0]  o_byte_index,
    output logic [7:0]        o_byte_value,
    output logic [7:0]        o_temp_whole,
    output logic [7:0]        o_temp_tenth,
    output logic              o_high_power,
    output logic              o_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg    cfg;
    t_result rx_res;
    t_result out_res;
    logic    rx_valid;
    logic    step;
    logic    q_full;

    // Input beat accepted
    assign step       = i_in_valid && !q_full;
    assign o_in_stall = q_full;

    tfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tfr_rx u_rx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_step      (step),
        .i_level     (i_line_level),
        .o_res_valid (rx_valid),
        .o_res       (rx_res)
    );

    tfr_oq u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rx_valid),
        .i_res   (rx_res),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    // Result fields
    assign o_event_kind = out_res.event_kind;
    assign o_byte_index = out_res.byte_index;
    assign o_byte_value = out_res.byte_value;
    assign o_temp_whole = out_res.temp_whole;
    assign o_temp_tenth = out_res.temp_tenth;
    assign o_high_power = out_res.high_power;
    assign o_last       = out_res.last;

endmodule

/* hw/rtl/tfr_cfg.sv */
// Configuration register bank behind the APB-style port.
module tfr_cfg
    import tfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_AW-1:2];
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_high_ticks    <= RST_IDLE_HIGH;
            r_cfg.absent_low_ticks   <= RST_ABSENT_LOW;
            r_cfg.first_sample_ticks <= RST_FIRST_SAMPLE;
            r_cfg.bit_ticks          <= RST_BIT_TICKS;
            r_cfg.high_power_code    <= RST_HIGH_POWER;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_IDLE_HIGH:    r_cfg.idle_high_ticks    <= pwdata[9:0];
                REG_ABSENT_LOW:   r_cfg.absent_low_ticks   <= pwdata[11:0];
                REG_FIRST_SAMPLE: r_cfg.first_sample_ticks <= pwdata[7:0];
                REG_BIT_TICKS:    r_cfg.bit_ticks          <= pwdata[7:0];
                REG_HIGH_POWER:   r_cfg.high_power_code    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        unique case (reg_idx)
            REG_IDLE_HIGH:    prdata = APB_DW'(r_cfg.idle_high_ticks);
            REG_ABSENT_LOW:   prdata = APB_DW'(r_cfg.absent_low_ticks);
            REG_FIRST_SAMPLE: prdata = APB_DW'(r_cfg.first_sample_ticks);
            REG_BIT_TICKS:    prdata = APB_DW'(r_cfg.bit_ticks);
            REG_HIGH_POWER:   prdata = APB_DW'(r_cfg.high_power_code);
            default:          prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/tfr_rx.sv */
// Link qualification, bit sampling and frame decode, one tick per beat.
module tfr_rx
    import tfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_step,
    input  logic    i_level,
    output logic    o_res_valid,
    output t_result o_res
);

    typedef enum logic [2:0] {
        PH_QUALIFY,
        PH_HUNT,
        PH_SAMPLE,
        PH_GAP_HUNT,
        PH_GAP_QUALIFY
    } t_phase;

    t_phase           r_phase,     n_phase;
    logic [9:0]       r_high_run,  n_high_run;
    logic [12:0]      r_low_total, n_low_total;
    logic [7:0]       r_tick,      n_tick;
    logic [3:0]       r_bit,       n_bit;
    logic [7:0]       r_shift,     n_shift;
    logic [IDX_W-1:0] r_byte_cnt,  n_byte_cnt;
    logic [7:0]       r_store [FRAME_BYTES];

    logic             emit;
    logic             store_we;
    logic [IDX_W-1:0] idx;
    logic             is_last;
    logic [9:0]       high_inc;
    logic [12:0]      low_inc;
    logic [7:0]       bt_eff;
    logic [7:0]       byte_type;
    logic [7:0]       byte_whole;
    logic [7:0]       byte_tenth;
    logic [7:0]       tenth_adj;
    t_result          res;

    assign high_inc = r_high_run + 10'd1;
    assign low_inc  = r_low_total + 13'd1;
    assign bt_eff   = at_least_one(i_cfg.bit_ticks);
    assign n_shift  = {i_level, r_shift[7:1]};
    assign idx      = (r_byte_cnt > LAST_IDX) ? LAST_IDX : r_byte_cnt;
    assign is_last  = (idx == LAST_IDX);

    // Eighth sample of a byte: the byte is complete this beat
    assign store_we = (r_phase == PH_SAMPLE) && (r_tick <= 8'd1) && (r_bit >= 4'd7);

    // Stored fields, bypassing the byte being written this beat
    assign byte_type  = (store_we && idx == IDX_TYPE)  ? n_shift : r_store[IDX_TYPE];
    assign byte_whole = (store_we && idx == IDX_WHOLE) ? n_shift : r_store[IDX_WHOLE];
    assign byte_tenth = (store_we && idx == IDX_TENTH) ? n_shift : r_store[IDX_TENTH];

    // Tenths correction, zeroed for a whole part of zero
    always_comb begin
        if (byte_whole == 8'd0) begin
            tenth_adj = 8'd0;
        end else if (byte_tenth > TENTH_LIMIT) begin
            tenth_adj = byte_tenth - TENTH_STEP;
        end else begin
            tenth_adj = byte_tenth + TENTH_STEP;
        end
    end

    // Next state and result
    always_comb begin
        n_phase     = r_phase;
        n_high_run  = r_high_run;
        n_low_total = r_low_total;
        n_tick      = r_tick;
        n_bit       = r_bit;
        n_byte_cnt  = r_byte_cnt;
        emit        = 1'b0;
        res         = '0;
        unique case (r_phase)
            PH_QUALIFY: begin
                if (i_level) begin
                    n_high_run = high_inc;
                    if (high_inc >= 10'(at_least_one(8'(0)) ) &&
                        high_inc >= ((i_cfg.idle_high_ticks == 10'd0) ?
                                     10'd1 : i_cfg.idle_high_ticks)) begin
                        n_phase     = PH_HUNT;
                        n_high_run  = '0;
                        n_low_total = '0;
                        n_byte_cnt  = '0;
                    end
                end else begin
                    n_high_run  = '0;
                    n_low_total = low_inc;
                    if (low_inc > 13'(i_cfg.absent_low_ticks)) begin
                        n_phase        = PH_QUALIFY;
                        n_low_total    = '0;
                        emit           = 1'b1;
                        res.event_kind = EV_ABSENT;
                    end
                end
            end
            PH_HUNT: begin
                if (!i_level) begin
                    n_phase = PH_SAMPLE;
                    n_tick  = at_least_one(i_cfg.first_sample_ticks);
                    n_bit   = '0;
                end
            end
            PH_SAMPLE: begin
                if (r_tick > 8'd1) begin
                    n_tick = r_tick - 8'd1;
                end else if (r_bit < 4'd7) begin
                    n_bit  = r_bit + 4'd1;
                    n_tick = bt_eff;
                end else begin
                    // Eighth sample completes the byte
                    emit           = 1'b1;
                    n_bit          = '0;
                    res.event_kind = EV_BYTE;
                    res.byte_index = idx;
                    res.byte_value = n_shift;
                    if (is_last) begin
                        res.temp_whole = byte_whole;
                        res.temp_tenth = tenth_adj;
                        res.high_power = (byte_type == i_cfg.high_power_code);
                        res.last       = 1'b1;
                        n_byte_cnt     = '0;
                    end else begin
                        n_byte_cnt = idx + IDX_W'(1);
                    end
                    if (bt_eff > 8'd1) begin
                        n_tick  = bt_eff - 8'd1;
                        n_phase = is_last ? PH_GAP_QUALIFY : PH_GAP_HUNT;
                    end else if (is_last) begin
                        n_phase     = PH_QUALIFY;
                        n_high_run  = '0;
                        n_low_total = '0;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            end
            PH_GAP_HUNT, PH_GAP_QUALIFY: begin
                if (r_tick > 8'd1) begin
                    n_tick = r_tick - 8'd1;
                end else begin
                    n_tick = '0;
                    if (r_phase == PH_GAP_QUALIFY) begin
                        n_phase     = PH_QUALIFY;
                        n_high_run  = '0;
                        n_low_total = '0;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            end
            default: begin
                n_phase     = PH_QUALIFY;
                n_high_run  = '0;
                n_low_total = '0;
            end
        endcase
    end

    assign o_res_valid = i_step && emit;
    assign o_res       = res;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_QUALIFY;
            r_high_run  <= '0;
            r_low_total <= '0;
            r_tick      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_byte_cnt  <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_high_run  <= n_high_run;
            r_low_total <= n_low_total;
            r_tick      <= n_tick;
            r_bit       <= n_bit;
            r_byte_cnt  <= n_byte_cnt;
            if (r_phase == PH_HUNT) begin
                r_shift <= '0;
            end else if (r_phase == PH_SAMPLE && r_tick <= 8'd1) begin
                r_shift <= n_shift;
            end
        end
    end

    // Frame store, no reset: each entry read is written earlier in the frame
    always_ff @(posedge i_clk) begin
        if (i_step && store_we) begin
            r_store[idx] <= n_shift;
        end
    end

endmodule

/* hw/rtl/tfr_oq.sv */
// Output register with skid stage for result beats.
`include "timed_serial_frame_receiver_core_macros.svh"

module tfr_oq
    import tfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop     = r_out_v && !i_stall;
    assign o_valid = r_out_v;
    assign o_res   = r_out;
    assign o_full  = r_skid_v;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_v && !pop) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (pop) begin
            r_out_v <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_v && !pop) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

    `TFR_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v,
        "skid stage holds a beat while the output register is empty")
    `TFR_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, i_push, !r_skid_v,
        "result pushed while both stages are occupied")
    `TFR_ASSERT_NEXT(a_skid_kept, i_clk, i_rst_n, r_skid_v && i_stall, r_skid_v && r_out_v,
        "buffered beat lost while the output is stalled")

endmodule

/* dv/timed_serial_frame_receiver_core_tb.sv */
// Self-checking testbench of the timed serial frame receiver core.
`timescale 1ns / 1ps

module timed_serial_frame_receiver_core_tb;
    import tfr_pkg::*;

    typedef enum logic [2:0] {
        RX_QUALIFY,
        RX_HUNT,
        RX_SAMPLE,
        RX_GAP_HUNT,
        RX_GAP_QUALIFY
    } t_rx_phase;

    typedef logic [7:0] t_frame [FRAME_BYTES];

    // Clock, reset and block ports
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_line_level = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_event_kind;
    logic [IDX_W-1:0]  o_byte_index;
    logic [7:0]        o_byte_value;
    logic [7:0]        o_temp_whole;
    logic [7:0]        o_temp_tenth;
    logic              o_high_power;
    logic              o_last;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Register copy and decoder state used for prediction
    t_cfg       cfg = '{RST_IDLE_HIGH, RST_ABSENT_LOW, RST_FIRST_SAMPLE, RST_BIT_TICKS,
                        RST_HIGH_POWER};
    t_rx_phase  rx_phase = RX_QUALIFY;
    logic [9:0] high_run = '0;
    logic [12:0] low_total = '0;
    logic [7:0] tick_cnt = '0;
    logic [3:0] bit_cnt = '0;
    logic [7:0] shift_reg = '0;
    logic [2:0] byte_cnt = '0;
    logic [7:0] frame_mem [FRAME_BYTES];

    // Line ticks waiting to be sent, events waiting to be seen
    bit      line_ticks [$];
    t_result pending_events [$];
    int      n_pushed = 0;
    int      events_seen = 0;
    int      errors = 0;
    bit      tail_quiet = 1'b0;
    logic    hold_off = 1'b0;
    int      snd_gap = 0;
    int      snd_calm = 0;
    int      rcv_burst = 0;
    int      rcv_calm = 0;

    timed_serial_frame_receiver_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_line_level (i_line_level),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_kind (o_event_kind),
        .o_byte_index (o_byte_index),
        .o_byte_value (o_byte_value),
        .o_temp_whole (o_temp_whole),
        .o_temp_tenth (o_temp_tenth),
        .o_high_power (o_high_power),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial forever #10 i_clk = ~i_clk;

    // Advance the decoder by one tick; returns 1 when the tick yields an event
    function automatic bit decode_tick(input logic level, output t_result ev);
        logic [7:0] fs_e;
        logic [7:0] bt_e;
        logic [9:0] idle_e;
        logic [7:0] whole;
        logic [7:0] tenth;
        logic [2:0] idx;
        logic       is_last;
        bit         produced;
        fs_e = (cfg.first_sample_ticks == 8'd0) ? 8'd1 : cfg.first_sample_ticks;
        bt_e = (cfg.bit_ticks == 8'd0) ? 8'd1 : cfg.bit_ticks;
        idle_e = (cfg.idle_high_ticks == 10'd0) ? 10'd1 : cfg.idle_high_ticks;
        ev = '0;
        produced = 1'b0;
        case (rx_phase)
            RX_QUALIFY: begin
                if (level) begin
                    high_run = high_run + 10'd1;
                    if (high_run >= idle_e) begin
                        rx_phase = RX_HUNT;
                        high_run = '0;
                        low_total = '0;
                        byte_cnt = '0;
                    end
                end else begin
                    high_run = '0;
                    low_total = low_total + 13'd1;
                    if (low_total > 13'(cfg.absent_low_ticks)) begin
                        high_run = '0;
                        low_total = '0;
                        ev.event_kind = EV_ABSENT;
                        produced = 1'b1;
                    end
                end
            end
            RX_HUNT: begin
                if (!level) begin
                    rx_phase = RX_SAMPLE;
                    tick_cnt = fs_e;
                    bit_cnt = '0;
                    shift_reg = '0;
                end
            end
            RX_SAMPLE: begin
                if (tick_cnt > 8'd1) begin
                    tick_cnt = tick_cnt - 8'd1;
                end else begin
                    shift_reg = {level, shift_reg[7:1]};
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt < 4'd8) begin
                        tick_cnt = bt_e;
                    end else begin
                        // Byte complete: store it and build the event
                        idx = (byte_cnt > LAST_IDX) ? LAST_IDX : byte_cnt;
                        frame_mem[idx] = shift_reg;
                        is_last = (idx == LAST_IDX);
                        ev.event_kind = EV_BYTE;
                        ev.byte_index = idx;
                        ev.byte_value = shift_reg;
                        if (is_last) begin
                            whole = frame_mem[IDX_WHOLE];
                            tenth = frame_mem[IDX_TENTH];
                            tenth = (tenth > TENTH_LIMIT) ? tenth - TENTH_STEP
                                                          : tenth + TENTH_STEP;
                            if (whole == 8'd0) tenth = 8'd0;
                            ev.temp_whole = whole;
                            ev.temp_tenth = tenth;
                            ev.high_power = (frame_mem[IDX_TYPE] == cfg.high_power_code);
                            ev.last = 1'b1;
                            byte_cnt = '0;
                        end else begin
                            byte_cnt = idx + 3'd1;
                        end
                        bit_cnt = '0;
                        if (bt_e > 8'd1) begin
                            tick_cnt = bt_e - 8'd1;
                            rx_phase = is_last ? RX_GAP_QUALIFY : RX_GAP_HUNT;
                        end else if (is_last) begin
                            rx_phase = RX_QUALIFY;
                            high_run = '0;
                            low_total = '0;
                        end else begin
                            rx_phase = RX_HUNT;
                        end
                        produced = 1'b1;
                    end
                end
            end
            RX_GAP_HUNT, RX_GAP_QUALIFY: begin
                if (tick_cnt > 8'd1) begin
                    tick_cnt = tick_cnt - 8'd1;
                end else begin
                    tick_cnt = '0;
                    if (rx_phase == RX_GAP_QUALIFY) begin
                        rx_phase = RX_QUALIFY;
                        high_run = '0;
                        low_total = '0;
                    end else begin
                        rx_phase = RX_HUNT;
                    end
                end
            end
            default: begin
                rx_phase = RX_QUALIFY;
                high_run = '0;
                low_total = '0;
            end
        endcase
        return produced;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic put_ticks(input bit level, input int n);
        repeat (n) line_ticks.push_back(level);
        n_pushed += n;
    endtask

    // One UART byte: start edge, samples at first_sample then every bit period
    task automatic send_byte(input logic [7:0] b);
        int fs_e;
        int bt_e;
        int p;
        bit lvl;
        fs_e = (cfg.first_sample_ticks == 0) ? 1 : cfg.first_sample_ticks;
        bt_e = (cfg.bit_ticks == 0) ? 1 : cfg.bit_ticks;
        put_ticks(1'b0, 1);
        for (p = 1; p <= fs_e + 7 * bt_e; p++) begin
            lvl = (p < fs_e) ? 1'b0 : b[(p - fs_e) / bt_e];
            // unsampled ticks may glitch
            if ((p < fs_e || (p - fs_e) % bt_e != 0) && $urandom_range(0, 5) == 0)
                lvl = $urandom_range(0, 1);
            put_ticks(lvl, 1);
        end
        for (p = 1; p < bt_e; p++)
            put_ticks(($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : 1, 1);
    endtask

    // Idle run to qualify the line, then the bytes of one frame
    task automatic send_frame(input t_frame fb);
        int idle_e;
        int k;
        idle_e = (cfg.idle_high_ticks == 0) ? 1 : cfg.idle_high_ticks;
        put_ticks(1'b0, $urandom_range(0, 2));
        put_ticks(1'b1, idle_e + $urandom_range(0, 3));
        for (k = 0; k < FRAME_BYTES; k++) begin
            send_byte(fb[k]);
            if (k < FRAME_BYTES - 1) put_ticks(1'b1, $urandom_range(0, 3));
        end
    endtask

    // Low run long enough to flag the partner absent once qualifying
    task automatic send_absence();
        int bt_e;
        bt_e = (cfg.bit_ticks == 0) ? 1 : cfg.bit_ticks;
        put_ticks(1'b0, bt_e - 1 + cfg.absent_low_ticks + 1 + $urandom_range(0, 2));
    endtask

    function automatic t_frame random_frame();
        t_frame f;
        foreach (f[k]) f[k] = $urandom_range(0, 255);
        if ($urandom_range(0, 1) == 1) f[IDX_TYPE] = cfg.high_power_code;
        if ($urandom_range(0, 7) == 0) f[IDX_WHOLE] = 8'd0;
        if ($urandom_range(0, 3) != 0) f[IDX_TENTH] = $urandom_range(0, 9);
        return f;
    endfunction

    task automatic wait_idle();
        while (line_ticks.size() != 0 || i_in_valid || pending_events.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup then access; upper data bits are sometimes junk
    task automatic reg_write(input logic [2:0] idx, input int unsigned val, input int w);
        logic [31:0] data;
        data = ($urandom_range(0, 1) == 1) ? ($urandom() << w) : 32'd0;
        data = data | (val & ((32'd1 << w) - 1));
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IDLE_HIGH:    cfg.idle_high_ticks    = data[9:0];
            REG_ABSENT_LOW:   cfg.absent_low_ticks   = data[11:0];
            REG_FIRST_SAMPLE: cfg.first_sample_ticks = data[7:0];
            REG_BIT_TICKS:    cfg.bit_ticks          = data[7:0];
            REG_HIGH_POWER:   cfg.high_power_code    = data[7:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int unsigned idle, input int unsigned absent,
                             input int unsigned fs, input int unsigned bt,
                             input int unsigned code);
        wait_idle();
        reg_write(REG_IDLE_HIGH, idle, 10);
        reg_write(REG_ABSENT_LOW, absent, 12);
        reg_write(REG_FIRST_SAMPLE, fs, 8);
        reg_write(REG_BIT_TICKS, bt, 8);
        reg_write(REG_HIGH_POWER, code, 8);
    endtask

    // Sender: one tick per beat, random gap bursts and calm stretches
    always @(posedge i_clk) begin : line_driver
        t_result ev;
        if (!i_rst_n) begin
            i_in_valid   <= 1'b0;
            i_line_level <= 1'b0;
            snd_gap = 0;
            snd_calm = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (decode_tick(i_line_level, ev)) pending_events.push_back(ev);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (snd_gap > 0) begin
                    snd_gap--;
                    i_in_valid <= 1'b0;
                end else if (line_ticks.size() > 0) begin
                    i_in_valid   <= 1'b1;
                    i_line_level <= line_ticks.pop_front();
                    // choose the gap that follows this beat
                    if (tail_quiet) begin
                        snd_calm = 0;
                    end else if (snd_calm > 0) begin
                        snd_calm--;
                    end else if ($urandom_range(0, 15) == 0) begin
                        snd_gap = $urandom_range(1, 11);
                    end else if ($urandom_range(0, 63) == 0) begin
                        snd_calm = $urandom_range(50, 400);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each event beat against the oldest prediction
    always @(posedge i_clk) begin : event_monitor
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rcv_burst = 0;
            rcv_calm = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                events_seen++;
                if (pending_events.size() == 0) begin
                    $error("event beat with none predicted: kind %0d index %0d value %0d",
                           o_event_kind, o_byte_index, o_byte_value);
                    errors++;
                end else begin
                    want = pending_events.pop_front();
                    check_field("event_kind", want.event_kind, o_event_kind);
                    check_field("byte_index", want.byte_index, o_byte_index);
                    check_field("byte_value", want.byte_value, o_byte_value);
                    check_field("temp_whole", want.temp_whole, o_temp_whole);
                    check_field("temp_tenth", want.temp_tenth, o_temp_tenth);
                    check_field("high_power", want.high_power, o_high_power);
                    check_field("last", want.last, o_last);
                end
            end
            if (tail_quiet) begin
                rcv_burst = 0;
            end else if (rcv_burst > 0) begin
                rcv_burst--;
            end else if (rcv_calm > 0) begin
                rcv_calm--;
            end else if ($urandom_range(0, 11) == 0) begin
                rcv_burst = $urandom_range(1, 11);
            end else if ($urandom_range(0, 79) == 0) begin
                rcv_calm = $urandom_range(50, 400);
            end
            i_out_stall <= hold_off || (rcv_burst > 0);
        end
    end

    // Long receiver hold-off while ticks keep coming, to back up the input
    initial begin : back_pressure
        while (events_seen < 10 || line_ticks.size() < 100) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (600) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : watchdog
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        t_frame frm;
        int     rand_start;
        int     pick;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!i_rst_n) @(posedge i_clk);

        // Directed: tenths correction both ways, zero whole, power match and miss
        configure(4, 20, 3, 2, 8'h24);
        put_ticks(1'b1, 3);
        put_ticks(1'b0, 1);
        frm = '{8'h00, 8'hFF, 8'h55, 8'h24, 8'h19, 8'h07, 8'hAA};
        send_frame(frm);
        frm = '{8'hFF, 8'h00, 8'h81, 8'h23, 8'h00, 8'h09, 8'h01};
        send_frame(frm);
        frm = '{8'h12, 8'h34, 8'h56, 8'h24, 8'hFF, 8'hFF, 8'hFE};
        send_frame(frm);
        frm = '{8'h7F, 8'h80, 8'h01, 8'h25, 8'h01, 8'h04, 8'h5A};
        send_frame(frm);
        send_absence();

        // Smallest tick counts, power code zero
        configure(1, 1, 1, 1, 8'h00);
        frm = '{8'h01, 8'h02, 8'h03, 8'h00, 8'h05, 8'h05, 8'hC3};
        send_frame(frm);
        send_absence();

        // Zero idle, sample and bit counts act as one; absence on the first low tick
        configure(0, 0, 0, 0, 8'hFF);
        frm = '{8'hA5, 8'h5A, 8'hF0, 8'hFF, 8'h14, 8'h03, 8'h0F};
        send_frame(frm);
        send_absence();

        // Random settings: mostly clean frames, some absences and line noise
        rand_start = n_pushed;
        while (n_pushed - rand_start < 450) begin
            configure($urandom_range(1, 24),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                  : $urandom_range(30, 300),
                      $urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(0, 255));
            repeat ($urandom_range(1, 3)) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    frm = random_frame();
                    send_frame(frm);
                end else if (pick == 7) begin
                    send_absence();
                end else begin
                    repeat ($urandom_range(4, 40)) put_ticks($urandom_range(0, 1), 1);
                end
            end
        end

        // Closing frame and absence, no idling on either side
        wait_idle();
        tail_quiet = 1'b1;
        configure(8, 12, 4, 2, $urandom_range(0, 255));
        frm = random_frame();
        send_frame(frm);
        send_absence();

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (errors == 0 && pending_events.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
